// ----- rtl/stream_session_client_fsm_unit_defines.svh -----
// Assertion helpers shared by the RTL. Each expects clk_i and rst_ni in scope.
`ifndef STREAM_SESSION_CLIENT_FSM_UNIT_DEFINES_SVH
`define STREAM_SESSION_CLIENT_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SSCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SSCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sscf_pkg.sv -----
package sscf_pkg;

  // Event codes
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_HELLO_ACK = 3'd1,
    OP_PONG      = 3'd2,
    OP_BYE       = 3'd3,
    OP_OTHER     = 3'd4,
    OP_VIDEO     = 3'd5,
    OP_TICK      = 3'd6,
    OP_LOCAL_BYE = 3'd7
  } op_e;

  // Result actions
  typedef enum logic [3:0] {
    ACT_VERDICT  = 4'd0,
    ACT_HELLO    = 4'd1,
    ACT_START    = 4'd2,
    ACT_PING     = 4'd3,
    ACT_KEYFRAME = 4'd4,
    ACT_BYE      = 4'd5,
    ACT_READY    = 4'd6,
    ACT_RTT      = 4'd7,
    ACT_DISC     = 4'd8
  } act_e;

  // Disconnect causes
  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_REJECTED = 3'd1,
    RSN_HOST_BYE = 3'd2,
    RSN_TIMEOUT  = 3'd3,
    RSN_LOST     = 3'd4
  } rsn_e;

  // Session phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HELLO     = 5'b00010,
    PH_STARTING  = 5'b00100,
    PH_STREAMING = 5'b01000,
    PH_DEAD      = 5'b10000
  } phase_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HELLO_GIVE_UP   = 3'd0,
    CFG_HELLO_RETRY     = 3'd1,
    CFG_SESSION_TIMEOUT = 3'd2,
    CFG_PING_INTERVAL   = 3'd3,
    CFG_KEYFRAME_RETRY  = 3'd4
  } cfg_idx_e;

  // Configuration reset values (microseconds)
  localparam logic [31:0] CFG_RST_HELLO_GIVE_UP   = 32'd5000000;
  localparam logic [31:0] CFG_RST_HELLO_RETRY     = 32'd250000;
  localparam logic [31:0] CFG_RST_SESSION_TIMEOUT = 32'd3000000;
  localparam logic [31:0] CFG_RST_PING_INTERVAL   = 32'd1000000;
  localparam logic [31:0] CFG_RST_KEYFRAME_RETRY  = 32'd500000;

  // Input event transfer
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] now_us;
    logic        packet_ok;
    logic [31:0] header_session_id;
    logic [31:0] ack_session_id;
    logic        ack_rejected;
    logic [63:0] pong_send_time_us;
    logic        want_keyframe;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  reason;
    logic [31:0] session_out;
    logic [31:0] ping_number;
    logic [63:0] ping_time_us;
    logic [31:0] rtt_us;
    logic        accepted;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/stream_session_client_fsm_unit.sv -----
// Client-side session handshake engine. Decoded events enter on in_data_i and the
// block answers with zero to three result transfers on out_data_o, the final one
// of each event marked by last. An event is captured in an input register, worked
// out combinationally against the session state, and its results are all loaded
// into a three-entry result buffer that drains one transfer per cycle while
// out_stall_i is low. An event that gives at most one result sustains one event
// per cycle under the same condition; an event with more results holds the result
// buffer, and the next event waits in the input register and is evaluated only
// once the last of those results is taken. Configuration writes are always
// taken (cfg_ready_o is tied high); writes to indexes past the fifth are ignored.
// TIME_BITS sets the width of the internal timestamps; time differences wrap
// modulo 2^TIME_BITS.
`include "stream_session_client_fsm_unit_defines.svh"

module stream_session_client_fsm_unit #(
  parameter int unsigned TIME_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sscf_pkg::in_item_t            in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sscf_pkg::out_item_t           out_data_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sscf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  typedef logic [TIME_BITS-1:0] tm_t;

  // configuration
  logic [31:0] give_up_q, retry_q, timeout_q, ping_int_q, kf_retry_q;

  // session state
  sscf_pkg::phase_e phase_q, phase_d;
  logic [31:0]      sid_q, sid_d;
  tm_t              started_q, started_d;
  tm_t              rcvd_q, rcvd_d;
  tm_t              sent_q, sent_d;
  tm_t              ping_at_q, ping_at_d;
  logic [31:0]      ping_num_q, ping_num_d;
  tm_t              kf_at_q, kf_at_d;
  logic [31:0]      rtt_q, rtt_d;

  // input register
  logic               in_valid_q;
  sscf_pkg::in_item_t in_q;

  // result buffer
  sscf_pkg::out_item_t res_q [3];
  sscf_pkg::out_item_t res_d [3];
  logic [1:0]          count_q;
  logic [1:0]          nres;

  logic in_take, pop, drained, proc;
  tm_t  now_t, pong_t;
  tm_t  d_start, d_sent, d_rcvd, d_ping, d_kf, d_pong;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = res_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign drained     = (count_q == 2'd0) || ((count_q == 2'd1) && pop);
  assign proc        = in_valid_q && drained;
  assign in_stall_o  = in_valid_q && !proc;
  assign in_take     = in_valid_i && !in_stall_o;

  // elapsed times, all modular
  assign now_t   = in_q.now_us[TIME_BITS-1:0];
  assign pong_t  = in_q.pong_send_time_us[TIME_BITS-1:0];
  assign d_start = now_t - started_q;
  assign d_sent  = now_t - sent_q;
  assign d_rcvd  = now_t - rcvd_q;
  assign d_ping  = now_t - ping_at_q;
  assign d_kf    = now_t - kf_at_q;
  assign d_pong  = now_t - pong_t;

  function automatic sscf_pkg::out_item_t mk_res(logic [3:0] act, logic [31:0] sid);
    sscf_pkg::out_item_t r;
    r             = '0;
    r.action      = act;
    r.session_out = sid;
    return r;
  endfunction

  function automatic sscf_pkg::out_item_t mk_verdict(logic ok);
    sscf_pkg::out_item_t r;
    r          = '0;
    r.action   = sscf_pkg::ACT_VERDICT;
    r.accepted = ok;
    return r;
  endfunction

  function automatic sscf_pkg::out_item_t mk_disc(logic [2:0] why);
    sscf_pkg::out_item_t r;
    r        = '0;
    r.action = sscf_pkg::ACT_DISC;
    r.reason = why;
    return r;
  endfunction

  // event evaluation: next state and the results of the registered event
  always_comb begin
    logic [1:0] k;
    logic       active;
    k          = 2'd0;
    active     = (phase_q == sscf_pkg::PH_STARTING) || (phase_q == sscf_pkg::PH_STREAMING);
    phase_d    = phase_q;
    sid_d      = sid_q;
    started_d  = started_q;
    rcvd_d     = rcvd_q;
    sent_d     = sent_q;
    ping_at_d  = ping_at_q;
    ping_num_d = ping_num_q;
    kf_at_d    = kf_at_q;
    rtt_d      = rtt_q;
    res_d[0]   = '0;
    res_d[1]   = '0;
    res_d[2]   = '0;

    case (in_q.op)
      sscf_pkg::OP_START: begin
        phase_d   = sscf_pkg::PH_HELLO;
        started_d = now_t;
        rcvd_d    = now_t;
        sent_d    = now_t;
        res_d[0]  = mk_res(sscf_pkg::ACT_HELLO, '0);
        k         = 2'd1;
      end
      sscf_pkg::OP_HELLO_ACK: begin
        if (!in_q.packet_ok) begin
          res_d[0] = mk_verdict(1'b0);
          k        = 2'd1;
        end else if (phase_q != sscf_pkg::PH_HELLO) begin
          res_d[0] = mk_verdict(1'b1);
          k        = 2'd1;
        end else if (in_q.ack_rejected) begin
          phase_d  = sscf_pkg::PH_DEAD;
          res_d[0] = mk_disc(sscf_pkg::RSN_REJECTED);
          res_d[1] = mk_verdict(1'b0);
          k        = 2'd2;
        end else begin
          sid_d    = in_q.ack_session_id;
          phase_d  = sscf_pkg::PH_STARTING;
          rcvd_d   = now_t;
          sent_d   = now_t;
          res_d[0] = mk_res(sscf_pkg::ACT_READY, '0);
          res_d[1] = mk_res(sscf_pkg::ACT_START, in_q.ack_session_id);
          res_d[2] = mk_verdict(1'b1);
          k        = 2'd3;
        end
      end
      sscf_pkg::OP_PONG: begin
        if (!in_q.packet_ok || phase_q == sscf_pkg::PH_IDLE ||
            phase_q == sscf_pkg::PH_DEAD || in_q.header_session_id != sid_q) begin
          res_d[0] = mk_verdict(1'b0);
          k        = 2'd1;
        end else begin
          rcvd_d          = now_t;
          rtt_d           = d_pong[31:0];
          res_d[0]        = mk_res(sscf_pkg::ACT_RTT, '0);
          res_d[0].rtt_us = d_pong[31:0];
          res_d[1]        = mk_verdict(1'b1);
          k               = 2'd2;
        end
      end
      sscf_pkg::OP_BYE: begin
        if (in_q.packet_ok && in_q.header_session_id == sid_q && sid_q != '0) begin
          phase_d  = sscf_pkg::PH_DEAD;
          res_d[0] = mk_disc(sscf_pkg::RSN_HOST_BYE);
          res_d[1] = mk_verdict(1'b0);
          k        = 2'd2;
        end else begin
          res_d[0] = mk_verdict(1'b0);
          k        = 2'd1;
        end
      end
      sscf_pkg::OP_OTHER: begin
        res_d[0] = mk_verdict(1'b0);
        k        = 2'd1;
      end
      sscf_pkg::OP_VIDEO: begin
        if (active) begin
          phase_d = sscf_pkg::PH_STREAMING;
          rcvd_d  = now_t;
        end
      end
      sscf_pkg::OP_TICK: begin
        if (phase_q == sscf_pkg::PH_HELLO) begin
          // connect give-up, else hello resend
          if (d_start > tm_t'(give_up_q)) begin
            phase_d  = sscf_pkg::PH_DEAD;
            res_d[0] = mk_disc(sscf_pkg::RSN_TIMEOUT);
            k        = 2'd1;
          end else if (d_sent >= tm_t'(retry_q)) begin
            sent_d   = now_t;
            res_d[0] = mk_res(sscf_pkg::ACT_HELLO, '0);
            k        = 2'd1;
          end
        end else if (active) begin
          // start resend while starting
          if (phase_q == sscf_pkg::PH_STARTING && d_sent >= tm_t'(retry_q)) begin
            sent_d   = now_t;
            res_d[k] = mk_res(sscf_pkg::ACT_START, sid_q);
            k        = k + 2'd1;
          end
          if (d_rcvd > tm_t'(timeout_q)) begin
            phase_d  = sscf_pkg::PH_DEAD;
            res_d[k] = mk_disc(sscf_pkg::RSN_LOST);
            k        = k + 2'd1;
          end else begin
            // periodic ping
            if (d_ping >= tm_t'(ping_int_q)) begin
              ping_at_d             = now_t;
              ping_num_d            = ping_num_q + 32'd1;
              res_d[k]              = mk_res(sscf_pkg::ACT_PING, sid_q);
              res_d[k].ping_number  = ping_num_q;
              res_d[k].ping_time_us = 64'(now_t);
              k                     = k + 2'd1;
            end
            // keyframe request
            if (in_q.want_keyframe && phase_q == sscf_pkg::PH_STREAMING &&
                d_kf >= tm_t'(kf_retry_q)) begin
              kf_at_d  = now_t;
              res_d[k] = mk_res(sscf_pkg::ACT_KEYFRAME, sid_q);
              k        = k + 2'd1;
            end
          end
        end
      end
      sscf_pkg::OP_LOCAL_BYE: begin
        if (active) begin
          res_d[0] = mk_res(sscf_pkg::ACT_BYE, sid_q);
          k        = 2'd1;
        end
        phase_d = sscf_pkg::PH_DEAD;
      end
      default: begin
        k = 2'd0;
      end
    endcase

    if (k != 2'd0) begin
      res_d[k - 2'd1].last = 1'b1;
    end
    nres = k;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      give_up_q  <= sscf_pkg::CFG_RST_HELLO_GIVE_UP;
      retry_q    <= sscf_pkg::CFG_RST_HELLO_RETRY;
      timeout_q  <= sscf_pkg::CFG_RST_SESSION_TIMEOUT;
      ping_int_q <= sscf_pkg::CFG_RST_PING_INTERVAL;
      kf_retry_q <= sscf_pkg::CFG_RST_KEYFRAME_RETRY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sscf_pkg::CFG_HELLO_GIVE_UP:   give_up_q  <= cfg_data_i;
        sscf_pkg::CFG_HELLO_RETRY:     retry_q    <= cfg_data_i;
        sscf_pkg::CFG_SESSION_TIMEOUT: timeout_q  <= cfg_data_i;
        sscf_pkg::CFG_PING_INTERVAL:   ping_int_q <= cfg_data_i;
        sscf_pkg::CFG_KEYFRAME_RETRY:  kf_retry_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // session state, updated when an event is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= sscf_pkg::PH_IDLE;
      sid_q      <= '0;
      started_q  <= '0;
      rcvd_q     <= '0;
      sent_q     <= '0;
      ping_at_q  <= '0;
      ping_num_q <= '0;
      kf_at_q    <= '0;
      rtt_q      <= '0;
    end else if (proc) begin
      phase_q    <= phase_d;
      sid_q      <= sid_d;
      started_q  <= started_d;
      rcvd_q     <= rcvd_d;
      sent_q     <= sent_d;
      ping_at_q  <= ping_at_d;
      ping_num_q <= ping_num_d;
      kf_at_q    <= kf_at_d;
      rtt_q      <= rtt_d;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_take || (in_valid_q && !proc);
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // result buffer fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (proc) begin
      count_q <= nres;
    end else if (pop) begin
      count_q <= count_q - 2'd1;
    end
  end

  // result buffer entries: load all at once, shift out one per transfer
  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  // checks
  `SSCF_ASSERT_IMP(a_load_when_drained, proc, (count_q == 2'd0) || (count_q == 2'd1 && pop), "result buffer overwritten before it drained")
  `SSCF_ASSERT_IMP(a_final_entry_last, out_valid_o && count_q == 2'd1, out_data_o.last, "final buffered result lacks last flag")
  `SSCF_ASSERT_IMP(a_disc_means_dead, out_valid_o && out_data_o.action == sscf_pkg::ACT_DISC, phase_q == sscf_pkg::PH_DEAD, "disconnect result while session not dead")
  `SSCF_ASSERT_NXT(a_held_event_stays, in_valid_q && !proc, in_valid_q && $stable(in_q), "held event lost or changed")

endmodule
